@@ rtl/core/bss_pkg.sv @@
`timescale 1ns / 1ps

package bss_pkg;

  localparam int OUT_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int ORDER_W = 4;
  localparam int CMD_W   = 2;
  localparam int IN_W    = 2 * BYTE_W;
  localparam int RES_W   = 8 * OUT_W;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_FEED  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef struct packed {
    logic load;
    logic step;
    logic clear;
    logic lookup;
    logic restart;
  } bss_ctrl_t;

endpackage

@@ rtl/core/bit_stream_statistics_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tuser command, tdata bytes
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata eight 32-bit counters
// cfg       in         cfg_valid / cfg_ready           cfg_data block_order
//
// Feed beat: one stream bit per cycle, for each of the byte's eight bits, through the
//   byte shift register, then one histogram RAM read and one result load.
// Read or unknown command beat: one histogram RAM read and one result load. Clear beat:
//   the histogram RAM is zeroed one entry per cycle, then one RAM read and one result load.
// Reset starts the same zeroing pass; s_axis_tready stays low meanwhile.
// A waiting result does not block acceptance of the next beat; a new result waits
//   until the output register is free.

module bit_stream_statistics_top
  import bss_pkg::*;
#(
  parameter int MAX_ORDER   = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [IN_W-1:0]    s_axis_tdata,  // data_byte, bin_index
  input  logic [CMD_W-1:0]   s_axis_tuser,  // command
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [RES_W-1:0]   m_axis_tdata,  // zero_count, one_count, pair_00, pair_01,
                                            // pair_10, pair_11, bin_count, block_total
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [ORDER_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_SWEEP,
    ST_LOOKUP,
    ST_RESULT
  } state_t;

  state_t                 state;
  logic [2:0]             bit_cnt;
  logic [ORDER_W-1:0]     block_order;
  logic [BYTE_W-1:0]      bin_q;

  bss_ctrl_t              ctrl;
  logic                   s_accept;
  cmd_t                   cmd;
  logic                   stream_bit;
  logic                   busy;
  logic [COUNT_WIDTH-1:0] zero_count;
  logic [COUNT_WIDTH-1:0] one_count;
  logic [COUNT_WIDTH-1:0] pair_00;
  logic [COUNT_WIDTH-1:0] pair_01;
  logic [COUNT_WIDTH-1:0] pair_10;
  logic [COUNT_WIDTH-1:0] pair_11;
  logic [COUNT_WIDTH-1:0] bin_count;
  logic [COUNT_WIDTH-1:0] blocks_counted;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE) && !busy;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_t'(s_axis_tuser);

  always_comb begin
    ctrl.load    = s_accept && (cmd == CMD_FEED);
    ctrl.clear   = s_accept && (cmd == CMD_CLEAR);
    ctrl.step    = (state == ST_FEED);
    ctrl.lookup  = (state == ST_LOOKUP);
    ctrl.restart = cfg_valid && cfg_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_order <= ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      block_order <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      bin_q <= s_axis_tdata[IN_W-1:BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      bit_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != ST_RESULT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            bit_cnt <= '0;
            unique case (cmd)
              CMD_FEED:  state <= ST_FEED;
              CMD_CLEAR: state <= ST_SWEEP;
              default:   state <= ST_LOOKUP;
            endcase
          end
        end
        ST_FEED: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (&bit_cnt) begin
            state <= ST_LOOKUP;
          end
        end
        ST_SWEEP: begin
          if (!busy) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {OUT_W'(blocks_counted), OUT_W'(bin_count),
                              OUT_W'(pair_11), OUT_W'(pair_10),
                              OUT_W'(pair_01), OUT_W'(pair_00),
                              OUT_W'(one_count), OUT_W'(zero_count)};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  bss_bit_counter #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_bit_counter (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .data_byte (s_axis_tdata[BYTE_W-1:0]),
    .bit_out   (stream_bit),
    .zero_count(zero_count),
    .one_count (one_count),
    .pair_00   (pair_00),
    .pair_01   (pair_01),
    .pair_10   (pair_10),
    .pair_11   (pair_11)
  );

  bss_histogram #(
    .MAX_ORDER  (MAX_ORDER),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_histogram (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .bit_in        (stream_bit),
    .block_order   (block_order),
    .bin_index     (bin_q),
    .busy          (busy),
    .bin_count     (bin_count),
    .blocks_counted(blocks_counted)
  );

endmodule

@@ rtl/core/bss_bit_counter.sv @@
`timescale 1ns / 1ps

module bss_bit_counter
  import bss_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bss_ctrl_t              ctrl,
  input  logic [BYTE_W-1:0]      data_byte,
  output logic                   bit_out,
  output logic [COUNT_WIDTH-1:0] zero_count,
  output logic [COUNT_WIDTH-1:0] one_count,
  output logic [COUNT_WIDTH-1:0] pair_00,
  output logic [COUNT_WIDTH-1:0] pair_01,
  output logic [COUNT_WIDTH-1:0] pair_10,
  output logic [COUNT_WIDTH-1:0] pair_11
);

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  logic [BYTE_W-1:0] shreg;
  logic              have_previous;
  logic              previous_bit;

  assign bit_out = shreg[BYTE_W-1];

  // shift out most significant bit first
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      shreg <= data_byte;
    end else if (ctrl.step) begin
      shreg <= {shreg[BYTE_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      have_previous <= 1'b0;
      previous_bit  <= 1'b0;
      zero_count    <= '0;
      one_count     <= '0;
      pair_00       <= '0;
      pair_01       <= '0;
      pair_10       <= '0;
      pair_11       <= '0;
    end else if (ctrl.step) begin
      have_previous <= 1'b1;
      previous_bit  <= bit_out;
      if (bit_out) begin
        one_count <= sat_inc(one_count);
      end else begin
        zero_count <= sat_inc(zero_count);
      end
      if (have_previous) begin
        unique case ({previous_bit, bit_out})
          2'b00: pair_00 <= sat_inc(pair_00);
          2'b01: pair_01 <= sat_inc(pair_01);
          2'b10: pair_10 <= sat_inc(pair_10);
          2'b11: pair_11 <= sat_inc(pair_11);
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/core/bss_histogram.sv @@
`timescale 1ns / 1ps

module bss_histogram
  import bss_pkg::*;
#(
  parameter int MAX_ORDER   = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bss_ctrl_t              ctrl,
  input  logic                   bit_in,
  input  logic [ORDER_W-1:0]     block_order,
  input  logic [BYTE_W-1:0]      bin_index,
  output logic                   busy,
  output logic [COUNT_WIDTH-1:0] bin_count,
  output logic [COUNT_WIDTH-1:0] blocks_counted
);

  localparam int DEPTH = 1 << MAX_ORDER;
  localparam int POS_W = $clog2(MAX_ORDER + 1);

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rdata;
  logic [COUNT_WIDTH-1:0] fwd_data;
  logic                   fwd;
  logic [MAX_ORDER-1:0]   partial_block;
  logic [POS_W-1:0]       block_bit_position;
  logic                   pend;
  logic [MAX_ORDER-1:0]   pend_addr;
  logic                   sweeping;
  logic [MAX_ORDER-1:0]   sweep_addr;
  logic                   hit;

  logic [POS_W-1:0]       eff_order;
  logic [POS_W-1:0]       pos_inc;
  logic                   block_done;
  logic [MAX_ORDER-1:0]   part_shift;
  logic                   re;
  logic [MAX_ORDER-1:0]   raddr;
  logic                   we;
  logic [MAX_ORDER-1:0]   waddr;
  logic [COUNT_WIDTH-1:0] wdata;
  logic [COUNT_WIDTH-1:0] rmw_val;

  always_comb begin
    priority if (block_order == '0) begin
      eff_order = POS_W'(1);
    end else if (block_order > ORDER_W'(MAX_ORDER)) begin
      eff_order = POS_W'(MAX_ORDER);
    end else begin
      eff_order = POS_W'(block_order);
    end
  end

  assign pos_inc    = block_bit_position + 1'b1;
  assign block_done = ctrl.step && (pos_inc >= eff_order);
  assign part_shift = (partial_block << 1) | MAX_ORDER'(bit_in);

  assign rmw_val = fwd ? fwd_data : rdata;
  assign re      = block_done || ctrl.lookup;
  assign raddr   = ctrl.lookup ? MAX_ORDER'(bin_index) : part_shift;
  assign we      = sweeping || pend;
  assign waddr   = sweeping ? sweep_addr : pend_addr;
  assign wdata   = sweeping ? '0 : sat_inc(rmw_val);

  assign busy      = sweeping;
  assign bin_count = hit ? rmw_val : '0;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata    <= mem[raddr];
      fwd_data <= wdata;
    end
    if (block_done) begin
      pend_addr <= part_shift;
    end
    if (ctrl.lookup) begin
      hit <= (bin_index >> eff_order) == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sweeping           <= 1'b1;
      sweep_addr         <= '0;
      partial_block      <= '0;
      block_bit_position <= '0;
      blocks_counted     <= '0;
      pend               <= 1'b0;
      fwd                <= 1'b0;
    end else begin
      if (sweeping) begin
        sweep_addr <= sweep_addr + 1'b1;
        if (&sweep_addr) begin
          sweeping <= 1'b0;
        end
      end
      // forward a write that lands on the address read in the same cycle
      if (re) begin
        fwd <= we && (waddr == raddr);
      end
      pend <= block_done;
      if (ctrl.restart || block_done) begin
        partial_block      <= '0;
        block_bit_position <= '0;
      end else if (ctrl.step) begin
        partial_block      <= part_shift;
        block_bit_position <= pos_inc;
      end
      if (block_done) begin
        blocks_counted <= sat_inc(blocks_counted);
      end
    end
  end

endmodule

@@ rtl/core/bss_checker.sv @@
`timescale 1ns / 1ps

module bss_checker
  import bss_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [IN_W-1:0]    s_axis_tdata,
  input logic [CMD_W-1:0]   s_axis_tuser,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [RES_W-1:0]   m_axis_tdata,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // waiting input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable({s_axis_tuser, s_axis_tdata}))
    else $error("input beat changed while waiting");

  // one beat at a time in flight
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input beat accepted back to back");

  // reset empties the output and starts the RAM zeroing pass
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("outputs not quiet after reset");

  // config port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind bit_stream_statistics_top bss_checker u_bss_checker (.*);
